>>> hw/rtl/rgbr_pkg.sv
// rgbr_pkg: shared types, constants and reference color table for the
// RGB ratio nearest color classifier. No dependencies.
package rgbr_pkg;

   localparam int PERIOD_W   = 14;
   localparam int LEVEL_W    = 8;
   localparam int CODE_W     = 4;
   localparam int SUM_W      = 16;
   localparam int DIVIDEND_W = 21;   // 100 * 16383 < 2**21
   localparam int SQ_W       = 16;
   localparam int DIST_W     = 18;   // three squares of 8-bit differences
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [CODE_W-1:0] CODE_NONE = 4'd9;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LIMIT  = 2'd2;

   // Color channel selectors
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // Reference triples; slots past the ninth are black
   localparam logic [LEVEL_W-1:0] REF_R [16] =
      '{8'd28, 8'd32, 8'd31, 8'd32, 8'd29, 8'd25, 8'd25, 8'd27,
        8'd31, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0};
   localparam logic [LEVEL_W-1:0] REF_G [16] =
      '{8'd33, 8'd32, 8'd35, 8'd29, 8'd36, 8'd33, 8'd31, 8'd30,
        8'd34, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0};
   localparam logic [LEVEL_W-1:0] REF_B [16] =
      '{8'd40, 8'd36, 8'd34, 8'd39, 8'd37, 8'd44, 8'd42, 8'd41,
        8'd37, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATIO_START,
      ST_RATIO_WAIT,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_SEARCH_START,
      ST_SEARCH_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [PERIOD_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [LEVEL_W-1:0] ref_level(input logic [CODE_W-1:0] idx,
                                                    input logic [1:0] ch);
      logic [LEVEL_W-1:0] lvl;
      case (ch)
         CH_RED:   lvl = REF_R[idx];
         CH_GREEN: lvl = REF_G[idx];
         CH_BLUE:  lvl = REF_B[idx];
         default:  lvl = '0;
      endcase
      return lvl;
   endfunction

endpackage

>>> hw/rtl/rgbr_divider.sv
// rgbr_divider: shared restoring divider, 8 quotient bits, saturating at 255.
// Depends on rgbr_pkg.
module rgbr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbr_pkg::div_req_type req,
   output rgbr_pkg::div_rsp_type rsp
);
   import rgbr_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [2:0]            cnt_ff;
   logic [DIVIDEND_W-1:0] rem_ff;
   logic [DIVIDEND_W-1:0] dsh_ff;
   logic [LEVEL_W-1:0]    quot_ff;
   logic                  sat;
   logic                  ge;

   // quotient would need a ninth bit (or divisor is zero): clamp to 255
   assign sat = {1'b0, req.dividend} >= {req.divisor, 8'b0};
   assign ge  = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            if (sat) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && cnt_ff == 3'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.dividend;
         dsh_ff  <= {req.divisor, 7'b0};
         cnt_ff  <= 3'd7;
         quot_ff <= sat ? {LEVEL_W{1'b1}} : '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? rem_ff - dsh_ff : rem_ff;
         dsh_ff  <= dsh_ff >> 1;
         cnt_ff  <= cnt_ff - 3'd1;
         quot_ff <= {quot_ff[LEVEL_W-2:0], ge};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

>>> hw/rtl/rgbr_nearest.sv
// rgbr_nearest: nearest reference search, one squared difference per cycle
// through a single 8x8 squarer. Depends on rgbr_pkg.
module rgbr_nearest #(
   parameter int NUM_COLORS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [7:0]  avg_red,
   input  logic [7:0]  avg_green,
   input  logic [7:0]  avg_blue,
   input  logic [7:0]  match_limit,
   output logic        done,
   output logic [3:0]  color_code
);
   import rgbr_pkg::*;

   localparam logic [CODE_W-1:0] LAST_IDX = CODE_W'(NUM_COLORS - 1);

   logic                active_ff;
   logic                lim_step_ff;
   logic [CODE_W-1:0]   idx_ff;
   logic [1:0]          ch_ff;

   logic [LEVEL_W-1:0]  avg_sel;
   logic [LEVEL_W-1:0]  op_a;
   logic [LEVEL_W-1:0]  op_b;
   logic [LEVEL_W-1:0]  diff;
   logic [SQ_W-1:0]     sq_in;
   logic                final_step;

   logic                sq_vld_ff;
   logic                sq_lim_ff;
   logic                sq_first_ff;
   logic                sq_last_ff;
   logic                sq_final_ff;
   logic [CODE_W-1:0]   sq_idx_ff;
   logic [SQ_W-1:0]     sq_ff;

   logic [DIST_W-1:0]   dist_sum;
   logic [DIST_W-1:0]   acc_ff;
   logic [DIST_W-1:0]   best_ff;
   logic [CODE_W-1:0]   code_ff;
   logic                done_ff;

   always_comb begin
      case (ch_ff)
         CH_RED:   avg_sel = avg_red;
         CH_GREEN: avg_sel = avg_green;
         CH_BLUE:  avg_sel = avg_blue;
         default:  avg_sel = '0;
      endcase
   end

   // first step squares the match limit to seed the best distance
   assign op_a       = lim_step_ff ? match_limit : avg_sel;
   assign op_b       = lim_step_ff ? '0 : ref_level(idx_ff, ch_ff);
   assign diff       = (op_a >= op_b) ? op_a - op_b : op_b - op_a;
   assign sq_in      = {8'b0, diff} * {8'b0, diff};
   assign final_step = !lim_step_ff && ch_ff == CH_BLUE && idx_ff == LAST_IDX;
   assign dist_sum   = (sq_first_ff ? '0 : acc_ff) + {2'b0, sq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         sq_vld_ff <= active_ff;
         done_ff   <= sq_vld_ff && sq_final_ff;
         if (start) begin
            active_ff <= 1'b1;
         end else if (active_ff && final_step) begin
            active_ff <= 1'b0;
         end
      end
   end

   // step sequencer: limit, then (color, channel) pairs
   always_ff @(posedge clock) begin
      if (start) begin
         lim_step_ff <= 1'b1;
         idx_ff      <= '0;
         ch_ff       <= CH_RED;
      end else if (active_ff) begin
         if (lim_step_ff) begin
            lim_step_ff <= 1'b0;
         end else if (ch_ff == CH_BLUE) begin
            ch_ff  <= CH_RED;
            idx_ff <= idx_ff + 1'b1;
         end else begin
            ch_ff <= ch_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      sq_lim_ff   <= lim_step_ff;
      sq_first_ff <= ch_ff == CH_RED;
      sq_last_ff  <= ch_ff == CH_BLUE;
      sq_final_ff <= final_step;
      sq_idx_ff   <= idx_ff;
   end

   // accumulate and keep the strictly smaller distance, first index on ties
   always_ff @(posedge clock) begin
      if (sq_vld_ff) begin
         if (sq_lim_ff) begin
            best_ff <= {2'b0, sq_ff};
            code_ff <= CODE_NONE;
         end else begin
            acc_ff <= dist_sum;
            if (sq_last_ff && dist_sum < best_ff) begin
               best_ff <= dist_sum;
               code_ff <= sq_idx_ff;
            end
         end
      end
   end

   assign done       = done_ff;
   assign color_code = code_ff;

endmodule

>>> hw/rtl/rgb_ratio_nearest_color_classifier_unit.sv
// rgb_ratio_nearest_color_classifier_unit: top level, sequencer, sums and csrs.
// Depends on rgbr_pkg, rgbr_divider, rgbr_nearest.
//
// Usage: each req word carries the clear, red, green and blue pulse periods of
// one measurement. Per channel the unit forms min(255, 100*clear/period) (255
// for a zero period) and adds it to a running sum. When the number of words
// taken reaches sample_count, the sums are divided by that number and the
// nearest reference color is looked up; one rsp word then carries the code
// and the three averages, and the sums clear.
// Timing: all divisions run through one 8-step divider (it skips the steps when
// the ratio saturates) and the search through one squarer, one channel per
// cycle. Each word takes three ratio divisions; one that closes a batch also
// takes three averaging divisions and the search before rsp_tvalid rises.
// req_tready is high only while idle.
// The rsp word sits in an output register until rsp_tready takes it; no new
// req word is accepted until then. csr writes are accepted every cycle
// (csr_ready tied high) and must only be made while the unit is idle.
// Reset (synchronous, active high) clears sums and count and loads
// sample_count = 1, far_limit = 333, match_limit = 100.
module rgb_ratio_nearest_color_classifier_unit #(
   parameter int NUM_COLORS = 9
) (
   input  logic        clock,
   input  logic        reset,
   // clear_period[13:0], red_period[27:14], green_period[41:28], blue_period[55:42]
   input  logic [55:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // color_code[3:0], avg_red[11:4], avg_green[19:12], avg_blue[27:20], zero[31:28]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);
   import rgbr_pkg::*;

   state_type state_ff, state_in;

   logic [7:0]            sample_count_ff;
   logic [PERIOD_W-1:0]   far_limit_ff;
   logic [7:0]            match_limit_ff;

   logic [PERIOD_W-1:0]   clear_ff;
   logic [PERIOD_W-1:0]   filt_ff [3];
   logic [SUM_W-1:0]      sum_ff [3];
   logic [LEVEL_W-1:0]    avg_ff [3];
   logic [7:0]            taken_ff;
   logic [7:0]            taken_in;
   logic [7:0]            need;
   logic [1:0]            ch_ff;

   logic [CODE_W-1:0]     out_code_ff;
   logic [LEVEL_W-1:0]    out_avg_ff [3];

   logic [DIVIDEND_W-1:0] clear_x100;
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic                  nn_start;
   logic                  nn_done;
   logic [CODE_W-1:0]     nn_code;

   assign clear_x100 = {1'b0, clear_ff, 6'b0} + {2'b0, clear_ff, 5'b0}
                     + {5'b0, clear_ff, 2'b0};
   assign taken_in   = taken_ff + 8'd1;
   assign need       = (sample_count_ff == 8'd0) ? 8'd1 : sample_count_ff;

   rgbr_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rgbr_nearest #(.NUM_COLORS(NUM_COLORS)) u_nearest (
      .clock       (clock),
      .reset       (reset),
      .start       (nn_start),
      .avg_red     (avg_ff[0]),
      .avg_green   (avg_ff[1]),
      .avg_blue    (avg_ff[2]),
      .match_limit (match_limit_ff),
      .done        (nn_done),
      .color_code  (nn_code)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RATIO_START;
         end
         ST_RATIO_START: state_in = ST_RATIO_WAIT;
         ST_RATIO_WAIT: begin
            if (div_rsp.done) begin
               if (ch_ff != CH_BLUE)    state_in = ST_RATIO_START;
               else if (taken_in >= need) state_in = ST_AVG_START;
               else                     state_in = ST_IDLE;
            end
         end
         ST_AVG_START: state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               state_in = (ch_ff == CH_BLUE) ? ST_SEARCH_START : ST_AVG_START;
            end
         end
         ST_SEARCH_START: state_in = ST_SEARCH_WAIT;
         ST_SEARCH_WAIT: begin
            if (nn_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready       = state_ff == ST_IDLE;
      rsp_tvalid       = state_ff == ST_OUT;
      nn_start         = state_ff == ST_SEARCH_START;
      div_req.start    = state_ff == ST_RATIO_START || state_ff == ST_AVG_START;
      if (state_ff == ST_RATIO_START) begin
         div_req.dividend = clear_x100;
         div_req.divisor  = filt_ff[ch_ff];
      end else begin
         div_req.dividend = {5'b0, sum_ff[ch_ff]};
         div_req.divisor  = {6'b0, taken_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_count_ff <= 8'd1;
         far_limit_ff    <= 14'd333;
         match_limit_ff  <= 8'd100;
         taken_ff        <= '0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_data[7:0];
               CSR_FAR_LIMIT:    far_limit_ff    <= csr_data;
               CSR_MATCH_LIMIT:  match_limit_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_RATIO_WAIT && div_rsp.done) begin
            sum_ff[ch_ff] <= sum_ff[ch_ff] + {8'b0, div_rsp.quotient};
            if (ch_ff == CH_BLUE) taken_ff <= taken_in;
         end
         if (state_ff == ST_SEARCH_WAIT && nn_done) begin
            taken_ff <= '0;
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         clear_ff   <= req_tdata[13:0];
         filt_ff[0] <= req_tdata[27:14];
         filt_ff[1] <= req_tdata[41:28];
         filt_ff[2] <= req_tdata[55:42];
         ch_ff      <= CH_RED;
      end else if (div_rsp.done &&
                   (state_ff == ST_RATIO_WAIT || state_ff == ST_AVG_WAIT)) begin
         ch_ff <= (ch_ff == CH_BLUE) ? CH_RED : ch_ff + 2'd1;
      end
      if (state_ff == ST_AVG_WAIT && div_rsp.done) begin
         avg_ff[ch_ff] <= div_rsp.quotient;
      end
      if (state_ff == ST_SEARCH_WAIT && nn_done) begin
         out_code_ff <= (clear_ff > far_limit_ff) ? CODE_NONE : nn_code;
         for (int i = 0; i < 3; i++) out_avg_ff[i] <= avg_ff[i];
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_tdata = {4'b0, out_avg_ff[2], out_avg_ff[1], out_avg_ff[0], out_code_ff};

endmodule

>>> sim/tb_rgb_ratio_nearest_color_classifier_unit.sv
`timescale 1ns / 100ps
// Testbench for rgb_ratio_nearest_color_classifier_unit: directed and random measurements,
// predicted averages and color codes checked against each rsp word. Depends on rgbr_pkg.
module tb_rgb_ratio_nearest_color_classifier_unit;
   import rgbr_pkg::*;

   typedef struct packed {
      logic [PERIOD_W-1:0] blue;
      logic [PERIOD_W-1:0] green;
      logic [PERIOD_W-1:0] red;
      logic [PERIOD_W-1:0] clear;
   } measurement_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [LEVEL_W-1:0] avg_red;
      logic [LEVEL_W-1:0] avg_green;
      logic [LEVEL_W-1:0] avg_blue;
   } color_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [55:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [13:0] csr_data = '0;

   rgb_ratio_nearest_color_classifier_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // reference colors
   int ref_red   [9] = '{28, 32, 31, 32, 29, 25, 25, 27, 31};
   int ref_green [9] = '{33, 32, 35, 29, 36, 33, 31, 30, 34};
   int ref_blue  [9] = '{40, 36, 34, 39, 37, 44, 42, 41, 37};

   // predictor state and register copies
   logic [7:0]  cfg_sample_count = 8'd1;
   logic [13:0] cfg_far_limit    = 14'd333;
   logic [7:0]  cfg_match_limit  = 8'd100;
   logic [15:0] sum_red = '0, sum_green = '0, sum_blue = '0;
   logic [7:0]  taken_count = '0;
   logic [13:0] last_clear = '0;

   color_result_type expected_colors [$];
   int errors = 0;
   bit idling_on = 1'b1;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;

   function automatic int pick_gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] color_ratio(input logic [13:0] clear, input logic [13:0] filt);
      logic [20:0] q;
      if (filt == '0)
         return 8'd255;
      q = (21'(clear) * 21'd100) / 21'(filt);
      return (q > 21'd255) ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [3:0] nearest_color(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      int best;
      int dist_sq;
      logic [3:0] code;
      code = CODE_NONE;
      if (last_clear > cfg_far_limit)
         return code;
      best = int'(cfg_match_limit) * int'(cfg_match_limit);
      for (int i = 0; i < 9; i++) begin
         dist_sq = (ref_red[i] - int'(r)) * (ref_red[i] - int'(r))
                 + (ref_green[i] - int'(g)) * (ref_green[i] - int'(g))
                 + (ref_blue[i] - int'(b)) * (ref_blue[i] - int'(b));
         if (dist_sq < best) begin
            best = dist_sq;
            code = 4'(i);
         end
      end
      return code;
   endfunction

   task automatic accumulate_measurement(input measurement_type m);
      logic [7:0] need;
      color_result_type res;
      sum_red   = sum_red + 16'(color_ratio(m.clear, m.red));
      sum_green = sum_green + 16'(color_ratio(m.clear, m.green));
      sum_blue  = sum_blue + 16'(color_ratio(m.clear, m.blue));
      last_clear = m.clear;
      taken_count = taken_count + 8'd1;
      need = (cfg_sample_count == 8'd0) ? 8'd1 : cfg_sample_count;
      if (taken_count >= need) begin
         res.avg_red   = 8'(sum_red / taken_count);
         res.avg_green = 8'(sum_green / taken_count);
         res.avg_blue  = 8'(sum_blue / taken_count);
         res.code      = nearest_color(res.avg_red, res.avg_green, res.avg_blue);
         expected_colors.push_back(res);
         sum_red = '0;
         sum_green = '0;
         sum_blue = '0;
         taken_count = '0;
      end
   endtask

   // filtered period that gives roughly the wanted level for this clear period
   function automatic logic [13:0] period_for_level(input int clear, input int level);
      int p;
      p = (clear * 100) / level;
      return (p > 10000) ? 14'd10000 : 14'(p);
   endfunction

   function automatic measurement_type make_measurement(input int clear, input int lr,
                                                        input int lg, input int lb);
      measurement_type m;
      m.clear = 14'(clear);
      m.red   = period_for_level(clear, lr);
      m.green = period_for_level(clear, lg);
      m.blue  = period_for_level(clear, lb);
      return m;
   endfunction

   function automatic measurement_type random_measurement();
      measurement_type m;
      int kind;
      int idx;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         // near a reference color, so matches and ties between neighbors show up
         idx = $urandom_range(0, 8);
         m = make_measurement($urandom_range(1, 2000), ref_red[idx] + $urandom_range(0, 6) - 3,
                              ref_green[idx] + $urandom_range(0, 6) - 3,
                              ref_blue[idx] + $urandom_range(0, 6) - 3);
      end else if (kind < 75) begin
         m.clear = 14'($urandom_range(0, 10000));
         m.red   = 14'($urandom_range(0, 10000));
         m.green = 14'($urandom_range(0, 10000));
         m.blue  = 14'($urandom_range(0, 10000));
      end else if (kind < 85) begin
         // timeouts on some channels
         m.clear = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(1, 10000));
         m.red   = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(1, 10000));
         m.green = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(1, 10000));
         m.blue  = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(1, 10000));
      end else begin
         // ratios past the saturation point
         m.clear = 14'($urandom_range(5000, 10000));
         m.red   = 14'($urandom_range(1, 100));
         m.green = 14'($urandom_range(1, 100));
         m.blue  = 14'($urandom_range(1, 100));
      end
      return m;
   endfunction

   task automatic send_measurement(input measurement_type m);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? pick_gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= m;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      accumulate_measurement(m);
   endtask

   // also covers words that close no batch and are still in flight
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [13:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SAMPLE_COUNT: cfg_sample_count = value[7:0];
         CSR_FAR_LIMIT:    cfg_far_limit = value;
         CSR_MATCH_LIMIT:  cfg_match_limit = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int samples, input int far, input int match);
      wait_results_drained();
      write_register(CSR_SAMPLE_COUNT, 14'(samples));
      write_register(CSR_FAR_LIMIT, 14'(far));
      write_register(CSR_MATCH_LIMIT, 14'(match));
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_color_word(input logic [31:0] word);
      color_result_type want;
      if (expected_colors.size() == 0) begin
         $display("%0t ns: rsp word %h with none expected", $time, word);
         errors++;
      end else begin
         want = expected_colors.pop_front();
         compare_field("color_code", want.code, word[3:0]);
         compare_field("avg_red", want.avg_red, word[11:4]);
         compare_field("avg_green", want.avg_green, word[19:12]);
         compare_field("avg_blue", want.avg_blue, word[27:20]);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_color_word(rsp_tdata);
   end

   // rsp side: long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = pick_gap_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_directed_cases();
      measurement_type m;
      send_measurement('0);                              // all timeouts
      m = '{blue: 14'd1, green: 14'd1, red: 14'd1, clear: 14'd10000};
      send_measurement(m);                               // saturated, out of range
      m = '{blue: 14'd10000, green: 14'd10000, red: 14'd10000, clear: 14'd0};
      send_measurement(m);
      m = '{blue: 14'd10000, green: 14'd10000, red: 14'd10000, clear: 14'd10000};
      send_measurement(m);
      m = '{blue: 14'd10000, green: 14'd5, red: 14'd0, clear: 14'd0};
      send_measurement(m);
      for (int i = 0; i < 9; i++)
         send_measurement(make_measurement(100, ref_red[i], ref_green[i], ref_blue[i]));
      send_measurement(make_measurement(100, 32, 30, 37));  // equidistant from two refs
      send_measurement(make_measurement(333, 32, 29, 39));  // clear right at far_limit
      send_measurement(make_measurement(334, 32, 29, 39));
   endtask

   task automatic test_register_extremes();
      set_config(1, 333, 0);
      send_measurement(make_measurement(100, 28, 33, 40));
      set_config(1, 10000, 255);
      send_measurement(make_measurement(10000, 60, 60, 60));
      set_config(1, 0, 255);
      send_measurement('{blue: 14'd5, green: 14'd5, red: 14'd5, clear: 14'd0});
      send_measurement('{blue: 14'd5, green: 14'd5, red: 14'd5, clear: 14'd1});
   endtask

   task automatic test_batch_size_changes();
      set_config(0, 333, 100);                           // zero count acts as one
      send_measurement(make_measurement(200, 30, 33, 38));
      send_measurement(make_measurement(200, 26, 31, 43));
      set_config(4, 333, 100);
      send_measurement(make_measurement(200, 30, 33, 38));
      send_measurement(make_measurement(200, 20, 40, 50));
      // count lowered with two words already summed
      set_config(1, 333, 100);
      send_measurement(make_measurement(200, 35, 30, 36));
   endtask

   task automatic test_random_phase(input int samples, input int far, input int match,
                                    input int count);
      set_config(samples, far, match);
      repeat (count) send_measurement(random_measurement());
   endtask

   task automatic test_back_to_back();
      wait_results_drained();
      idling_on = 1'b0;
      test_random_phase(1, 2000, 100, 60);
      wait_results_drained();
      idling_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      set_config(1, 10000, 255);
      rsp_hold_left = 400;
      repeat (20) send_measurement(random_measurement());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_batch_size_changes();
      test_back_to_back();
      test_output_backpressure();
      test_random_phase(1, 333, 100, 150);
      test_random_phase(2, 10000, 255, 150);
      test_random_phase(4, 5000, 20, 160);
      for (int i = 0; i < 3; i++)
         test_random_phase($urandom_range(1, 8), $urandom_range(0, 10000),
                           $urandom_range(0, 255), 80);
      test_random_phase(255, 10000, 255, 255);

      wait_results_drained();
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/rgbr_pkg.sv
hw/rtl/rgbr_divider.sv
hw/rtl/rgbr_nearest.sv
hw/rtl/rgb_ratio_nearest_color_classifier_unit.sv
sim/tb_rgb_ratio_nearest_color_classifier_unit.sv
